FILE: sv/lct_pkg.sv
// ---------------------------------------------------------------------------
// lct_pkg
// Types and constants for the LFU cache table: entry layout, request kinds
// and fixed field widths.
// ---------------------------------------------------------------------------
`default_nettype none

package lct_pkg;

  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 32;
  localparam int STAMP_W = 48;
  localparam int CFG_W   = 5;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  localparam logic [DATA_W-1:0]  MISS_VALUE = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] count;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

FILE: sv/lct_ram.sv
// ---------------------------------------------------------------------------
// lct_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module lct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/lfu_cache_table.sv
// ---------------------------------------------------------------------------
// lfu_cache_table
// Fully associative key-value store with least-frequently-used replacement,
// ties broken by least recent use. Entries live in one RAM; each request
// scans the filled slots, then writes the touched or new entry back.
//
//   channel  | dir | signals                          | payload
//   ---------+-----+----------------------------------+--------------------------
//   s_*      | in  | s_tvalid s_tready s_tdata s_tuser | request: kind, key, value
//   m_*      | out | m_tvalid m_tready m_tdata m_tuser | result: hit, read_value,
//            |     |                                  | evicted, evicted_key
//   cfg_*    | in  | cfg_valid cfg_ready cfg_data     | capacity_in_use
//
// A request is accepted, then each filled slot is read from the RAM in turn,
// the read pipe is drained and the touched or new entry is written back.
// Filled slots always form a prefix, so the fill count replaces valid bits.
// Reset empties the store, zeroes the access clock and sets capacity to 16.
// A stalled result holds the write-back; the next request is taken only
// after its result register has been loaded.
// ---------------------------------------------------------------------------
`default_nettype none

module lfu_cache_table #(
  parameter int CAPACITY = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // [31:0] key, [63:32] value
  input  wire logic [0:0]  s_tuser,   // [0] kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [63:0] m_tdata,   // [31:0] read_value, [63:32] evicted_key
  output logic      [1:0]  m_tuser,   // [0] hit, [1] evicted
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (OW > lct_pkg::CFG_W) ? OW : lct_pkg::CFG_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0] state;

  logic [lct_pkg::CFG_W-1:0]   capacity_in_use;
  logic [OW-1:0]               occupancy;
  logic [lct_pkg::STAMP_W-1:0] access_clock;

  logic                        req_kind;
  logic [lct_pkg::KEY_W-1:0]   req_key;
  logic [lct_pkg::DATA_W-1:0]  req_value;

  logic [OW-1:0] scan_idx;
  logic          cmp_valid;
  logic [AW-1:0] cmp_idx;

  logic                         found;
  logic [AW-1:0]                match_idx;
  logic [lct_pkg::DATA_W-1:0]   match_data;
  logic [lct_pkg::COUNT_W-1:0]  match_count;

  logic                         best_set;
  logic [AW-1:0]                best_idx;
  logic [lct_pkg::KEY_W-1:0]    best_key;
  logic [lct_pkg::COUNT_W-1:0]  best_count;
  logic [lct_pkg::STAMP_W-1:0]  best_stamp;

  logic [lct_pkg::ENTRY_W-1:0] ram_rdata;
  lct_pkg::entry_t             rd_entry;
  lct_pkg::entry_t             wr_entry;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;

  logic [CMPW-1:0] cap_ext;
  logic [CMPW-1:0] cap_sat;
  logic            cap_zero;
  logic            store_full;
  logic            s_xfer;
  logic            out_free;
  logic            finish;
  logic            better;
  logic            key_eq;

  logic                        res_hit;
  logic [lct_pkg::DATA_W-1:0]  res_value;
  logic                        res_evicted;
  logic [lct_pkg::KEY_W-1:0]   res_evicted_key;
  logic                        occ_inc;
  logic [lct_pkg::COUNT_W-1:0] count_next;

  assign cap_ext    = CMPW'(capacity_in_use);
  assign cap_sat    = (cap_ext > CMPW'(CAPACITY)) ? CMPW'(CAPACITY) : cap_ext;
  assign cap_zero   = (cap_sat == '0);
  assign store_full = (CMPW'(occupancy) >= cap_sat);

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign s_xfer    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign finish    = (state == ST_WRITE) && out_free;

  assign rd_entry = lct_pkg::entry_t'(ram_rdata);
  assign key_eq   = (rd_entry.key == req_key);
  assign better   = !best_set || (rd_entry.count < best_count) ||
                    ((rd_entry.count == best_count) && (rd_entry.stamp < best_stamp));

  assign count_next = (match_count == lct_pkg::COUNT_MAX) ? match_count
                                                          : match_count + 1'b1;

  lct_ram #(
    .WIDTH (lct_pkg::ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .raddr (scan_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    res_hit         = 1'b0;
    res_value       = '0;
    res_evicted     = 1'b0;
    res_evicted_key = '0;
    occ_inc         = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = match_idx;
    wr_entry.key    = req_key;
    wr_entry.data   = req_value;
    wr_entry.count  = count_next;
    wr_entry.stamp  = access_clock;
    if (req_kind == lct_pkg::KIND_GET) begin
      res_value = lct_pkg::MISS_VALUE;
      if (!cap_zero && found) begin
        res_hit       = 1'b1;
        res_value     = match_data;
        wr_entry.data = match_data;
        ram_we        = finish;
      end
    end else if (!cap_zero) begin
      if (found) begin
        res_hit = 1'b1;
        ram_we  = finish;
      end else begin
        wr_entry.count = lct_pkg::COUNT_ONE;
        ram_we         = finish;
        if (store_full) begin
          res_evicted     = 1'b1;
          res_evicted_key = best_key;
          ram_waddr       = best_idx;
        end else begin
          ram_waddr = occupancy[AW-1:0];
          occ_inc   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      capacity_in_use <= lct_pkg::CFG_W'(16);
      occupancy       <= '0;
      access_clock    <= '0;
      m_tvalid        <= 1'b0;
      cmp_valid       <= 1'b0;
      scan_idx        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity_in_use <= cfg_data;
      end
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_xfer) begin
            scan_idx  <= '0;
            cmp_valid <= 1'b0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_idx != occupancy) begin
            scan_idx  <= scan_idx + 1'b1;
            cmp_valid <= 1'b1;
          end else begin
            cmp_valid <= 1'b0;
            if (!cmp_valid) begin
              state <= ST_WRITE;
            end
          end
        end
        ST_WRITE: begin
          if (out_free) begin
            state <= ST_IDLE;
            if (ram_we) begin
              access_clock <= access_clock + 1'b1;
            end
            if (occ_inc) begin
              occupancy <= occupancy + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      req_kind  <= s_tuser[0];
      req_key   <= s_tdata[31:0];
      req_value <= s_tdata[63:32];
      found     <= 1'b0;
      best_set  <= 1'b0;
    end
    if (state == ST_SCAN) begin
      cmp_idx <= scan_idx[AW-1:0];
      if (cmp_valid) begin
        if (key_eq && !found) begin
          found       <= 1'b1;
          match_idx   <= cmp_idx;
          match_data  <= rd_entry.data;
          match_count <= rd_entry.count;
        end
        if (better) begin
          best_set   <= 1'b1;
          best_idx   <= cmp_idx;
          best_key   <= rd_entry.key;
          best_count <= rd_entry.count;
          best_stamp <= rd_entry.stamp;
        end
      end
    end
    if (finish) begin
      m_tdata <= {res_evicted_key, res_value};
      m_tuser <= {res_evicted, res_hit};
    end
  end

endmodule

`default_nettype wire

FILE: sim/lfu_cache_table_test.sv
// ---------------------------------------------------------------------------
// lfu_cache_table_test
// Self-checking testbench for the LFU cache table. A directed table covers
// empty-store misses, key and value extremes, put hits, capacity lowered
// below occupancy, a disabled store, capacity above the slot count and the
// least-recently-used tie-break. Random phases then cover several capacity
// settings with a small key pool so that hits and evictions are frequent.
// Every accepted request is run through a local LFU predictor; every result
// is checked field by field, in order, against it or a typed row's result.
// ---------------------------------------------------------------------------
`default_nettype none

module lfu_cache_table_test;

  localparam int SLOTS          = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 300;
  localparam int CFG_PAUSE      = 24;
  localparam int DRAIN_TAIL     = 40;
  localparam int PHASES         = 7;
  localparam int PHASE_ITEMS    = 70;
  localparam int DIR_ROWS       = 22;

  typedef struct packed {
    logic                       hit;
    logic [lct_pkg::DATA_W-1:0] read_value;
    logic                       evicted;
    logic [lct_pkg::KEY_W-1:0]  evicted_key;
  } result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_op_t;

  typedef struct packed {
    row_op_t                    op;
    logic                       kind;
    logic [lct_pkg::KEY_W-1:0]  key;
    logic [lct_pkg::DATA_W-1:0] value;
    logic [lct_pkg::CFG_W-1:0]  cap;
    logic                       typed;
    result_t                    exp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata   = '0;
  logic [0:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data  = '0;

  lfu_cache_table #(
    .CAPACITY(SLOTS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predictor copy of the store
  logic                        tbl_valid [SLOTS];
  logic [lct_pkg::KEY_W-1:0]   tbl_key   [SLOTS];
  logic [lct_pkg::DATA_W-1:0]  tbl_data  [SLOTS];
  logic [lct_pkg::COUNT_W-1:0] tbl_count [SLOTS];
  logic [lct_pkg::STAMP_W-1:0] tbl_stamp [SLOTS];
  logic [lct_pkg::STAMP_W-1:0] tbl_clock = '0;
  int                          tbl_fill  = 0;
  logic [lct_pkg::CFG_W-1:0]   tbl_cap   = lct_pkg::CFG_W'(16);

  result_t expected_results [$];
  int      fail_count  = 0;
  bit      quiet       = 1'b0;
  bit      rx_hold_req = 1'b0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
    end
  end

  function automatic void stamp_entry(input int slot);
    tbl_stamp[slot] = tbl_clock;
    tbl_clock       = tbl_clock + 1'b1;
  endfunction

  function automatic result_t predict_lfu(input logic kind,
                                          input logic [lct_pkg::KEY_W-1:0] k,
                                          input logic [lct_pkg::DATA_W-1:0] v);
    result_t r;
    int      cap;
    int      slot;
    int      victim;
    r    = '0;
    cap  = (tbl_cap > SLOTS) ? SLOTS : int'(tbl_cap);
    slot = -1;
    if (cap != 0) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot < 0 && tbl_valid[i] && tbl_key[i] == k) slot = i;
      end
    end
    if (kind == lct_pkg::KIND_GET) begin
      r.read_value = lct_pkg::MISS_VALUE;
      if (slot >= 0) begin
        r.hit        = 1'b1;
        r.read_value = tbl_data[slot];
        if (tbl_count[slot] != lct_pkg::COUNT_MAX)
          tbl_count[slot] = tbl_count[slot] + 1'b1;
        stamp_entry(slot);
      end
    end else if (cap != 0) begin
      if (slot >= 0) begin
        r.hit          = 1'b1;
        tbl_data[slot] = v;
        if (tbl_count[slot] != lct_pkg::COUNT_MAX)
          tbl_count[slot] = tbl_count[slot] + 1'b1;
        stamp_entry(slot);
      end else begin
        if (tbl_fill >= cap) begin
          victim = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (tbl_valid[i] && (victim < 0 || tbl_count[i] < tbl_count[victim] ||
                (tbl_count[i] == tbl_count[victim] && tbl_stamp[i] < tbl_stamp[victim])))
              victim = i;
          end
          if (victim >= 0) begin
            r.evicted         = 1'b1;
            r.evicted_key     = tbl_key[victim];
            tbl_valid[victim] = 1'b0;
            tbl_fill--;
          end
        end
        for (int i = 0; i < SLOTS; i++) begin
          if (slot < 0 && !tbl_valid[i]) slot = i;
        end
        if (slot >= 0) begin
          tbl_valid[slot] = 1'b1;
          tbl_key[slot]   = k;
          tbl_data[slot]  = v;
          tbl_count[slot] = lct_pkg::COUNT_ONE;
          stamp_entry(slot);
          tbl_fill++;
        end
      end
    end
    return r;
  endfunction

  task automatic send_request(input logic kind, input logic [lct_pkg::KEY_W-1:0] k,
                              input logic [lct_pkg::DATA_W-1:0] v, input logic typed,
                              input result_t typed_exp);
    result_t pred;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {v, k};
    do @(posedge clk); while (!s_tready);
    pred = predict_lfu(kind, k, v);
    expected_results.push_back(typed ? typed_exp : pred);
  endtask

  task automatic sender_gap();
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 7);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [lct_pkg::CFG_W-1:0] cap);
    drain_results();
    repeat (CFG_PAUSE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    tbl_cap = cap;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stall bursts, one long hold on request
  always begin
    @(negedge clk);
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      m_tready <= 1'b0;
      repeat (LONG_HOLD) @(negedge clk);
      m_tready <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
      m_tready <= 1'b1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: tuser %b tdata %h", m_tuser, m_tdata);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (m_tuser[0] !== exp_r.hit) begin
          $error("hit: expected %b, actual %b", exp_r.hit, m_tuser[0]);
          fail_count++;
        end
        if (m_tdata[31:0] !== exp_r.read_value) begin
          $error("read_value: expected %h, actual %h", exp_r.read_value, m_tdata[31:0]);
          fail_count++;
        end
        if (m_tuser[1] !== exp_r.evicted) begin
          $error("evicted: expected %b, actual %b", exp_r.evicted, m_tuser[1]);
          fail_count++;
        end
        if (m_tdata[63:32] !== exp_r.evicted_key) begin
          $error("evicted_key: expected %h, actual %h", exp_r.evicted_key, m_tdata[63:32]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("lfu_cache_table_test: FAIL");
      $finish;
    end
  end

  dir_row_t                  dir_rows   [DIR_ROWS];
  logic [lct_pkg::CFG_W-1:0] phase_caps [PHASES];
  logic [lct_pkg::KEY_W-1:0] key_pool   [SLOTS + 4];

  initial begin
    int                        pool_n;
    int                        cap_eff;
    logic                      kind;
    logic [lct_pkg::KEY_W-1:0] k;

    dir_rows = '{
      '{ROW_REQ, lct_pkg::KIND_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1,
        '{1'b0, lct_pkg::MISS_VALUE, 1'b0, 32'h0}},
      '{ROW_REQ, lct_pkg::KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 5'd0, 1'b1,
        '{1'b0, 32'h0, 1'b0, 32'h0}},
      '{ROW_REQ, lct_pkg::KIND_GET, 32'h7FFF_FFFF, 32'h0000_0000, 5'd0, 1'b1,
        '{1'b1, 32'h8000_0000, 1'b0, 32'h0}},
      '{ROW_REQ, lct_pkg::KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 5'd0, 1'b1,
        '{1'b0, 32'h0, 1'b0, 32'h0}},
      '{ROW_REQ, lct_pkg::KIND_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 5'd0, 1'b1,
        '{1'b1, 32'h0, 1'b0, 32'h0}},
      '{ROW_REQ, lct_pkg::KIND_GET, 32'h8000_0000, 32'hFFFF_FFFF, 5'd0, 1'b1,
        '{1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0}},
      '{ROW_CFG, lct_pkg::KIND_GET, 32'h0, 32'h0, 5'd1, 1'b0, '0},
      '{ROW_REQ, lct_pkg::KIND_PUT, 32'h0000_0005, 32'h0000_0001, 5'd0, 1'b0, '0},
      '{ROW_REQ, lct_pkg::KIND_PUT, 32'h0000_0006, 32'h0000_0002, 5'd0, 1'b0, '0},
      '{ROW_REQ, lct_pkg::KIND_GET, 32'h7FFF_FFFF, 32'h0000_0000, 5'd0, 1'b1,
        '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
      '{ROW_CFG, lct_pkg::KIND_GET, 32'h0, 32'h0, 5'd0, 1'b0, '0},
      '{ROW_REQ, lct_pkg::KIND_GET, 32'h7FFF_FFFF, 32'h0000_0000, 5'd0, 1'b1,
        '{1'b0, lct_pkg::MISS_VALUE, 1'b0, 32'h0}},
      '{ROW_REQ, lct_pkg::KIND_PUT, 32'h0000_0009, 32'h0000_0009, 5'd0, 1'b1,
        '{1'b0, 32'h0, 1'b0, 32'h0}},
      '{ROW_REQ, lct_pkg::KIND_GET, 32'h0000_0009, 32'h0000_0000, 5'd0, 1'b1,
        '{1'b0, lct_pkg::MISS_VALUE, 1'b0, 32'h0}},
      '{ROW_CFG, lct_pkg::KIND_GET, 32'h0, 32'h0, 5'd31, 1'b0, '0},
      '{ROW_REQ, lct_pkg::KIND_PUT, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b0, '0},
      '{ROW_CFG, lct_pkg::KIND_GET, 32'h0, 32'h0, 5'd2, 1'b0, '0},
      '{ROW_REQ, lct_pkg::KIND_PUT, 32'hFFFF_FFFF, 32'h5555_5555, 5'd0, 1'b0, '0},
      '{ROW_REQ, lct_pkg::KIND_PUT, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 5'd0, 1'b0, '0},
      '{ROW_REQ, lct_pkg::KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0, 1'b0, '0},
      '{ROW_CFG, lct_pkg::KIND_GET, 32'h0, 32'h0, 5'd16, 1'b0, '0},
      '{ROW_REQ, lct_pkg::KIND_GET, 32'h0000_0005, 32'h0000_0000, 5'd0, 1'b1,
        '{1'b0, lct_pkg::MISS_VALUE, 1'b0, 32'h0}}
    };
    phase_caps = '{5'd16, 5'd3, 5'd1, 5'd0, 5'd31, 5'd7, 5'd16};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].op == ROW_CFG) begin
        write_capacity(dir_rows[r].cap);
      end else begin
        send_request(dir_rows[r].kind, dir_rows[r].key, dir_rows[r].value,
                     dir_rows[r].typed, dir_rows[r].exp);
        sender_gap();
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_caps[p]);
      if (p == PHASES - 1) quiet = 1'b1;
      cap_eff = (phase_caps[p] > SLOTS) ? SLOTS : int'(phase_caps[p]);
      pool_n  = cap_eff + 4;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      for (int i = 2; i < pool_n; i++) key_pool[i] = $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 0 && n == 30) rx_hold_req = 1'b1;
        kind = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) < 8) k = key_pool[$urandom_range(0, pool_n - 1)];
        else k = $urandom;
        send_request(kind, k, $urandom, 1'b0, '0);
        sender_gap();
      end
    end

    drain_results();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (fail_count == 0) begin
      $display("lfu_cache_table_test: PASS");
    end else begin
      $display("lfu_cache_table_test: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
sv/lct_pkg.sv
sv/lct_ram.sv
sv/lfu_cache_table.sv
sim/lfu_cache_table_test.sv
